/* design/clcs_pkg.sv */
package clcs_pkg;

  // Command codes on the mode field.
  localparam logic [2:0] MODE_INIT       = 3'd0;
  localparam logic [2:0] MODE_CLEAR      = 3'd1;
  localparam logic [2:0] MODE_CURSOR_ON  = 3'd2;
  localparam logic [2:0] MODE_CURSOR_OFF = 3'd3;
  localparam logic [2:0] MODE_GOTO       = 3'd4;
  localparam logic [2:0] MODE_PUTCHAR    = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  localparam logic [2:0] ROW_COUNT_RESET    = 3'd2;
  localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
  localparam logic [2:0] ROWS_TWO           = 3'd2;
  localparam logic [2:0] ROWS_FOUR          = 3'd4;

  // Controller instructions.
  localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] DDRAM_ROW_ODD    = 8'h40;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_CURSOR_ON    = 8'h0E;
  localparam logic [7:0] CMD_CURSOR_OFF   = 8'h0C;
  localparam logic [7:0] CMD_BLINK_ON     = 8'h0F;
  localparam logic [3:0] NIB_8BIT_MODE    = 4'h3;
  localparam logic [3:0] NIB_4BIT_MODE    = 4'h2;

  localparam logic [6:0] WAIT_POWER_UP = 7'd100;
  localparam logic [6:0] WAIT_SECOND   = 7'd5;
  localparam logic [6:0] WAIT_SHORT    = 7'd1;
  localparam logic [1:0] WAIT_CLEAR    = 2'd3;

  localparam logic [6:0] WRAP_FOUR_ROWS = 7'd20;
  localparam logic [6:0] WRAP_OTHER     = 7'd40;

  localparam logic [4:0] BEATS_BYTE  = 5'd2;
  localparam logic [4:0] BEATS_WRAP  = 5'd4;
  localparam logic [4:0] BEATS_INIT  = 5'd28;
  localparam logic [4:0] BEATS_ROUND = 5'd14;

  typedef enum logic {KIND_BYTES, KIND_INIT} kind_t;

  typedef struct packed {
    logic [1:0] row;
    logic [5:0] column;
  } cursor_t;

  // Everything the sequencer needs to play out one command.
  typedef struct packed {
    kind_t      kind;
    logic [4:0] count;
    logic       rs0;
    logic [7:0] byte0;
    logic [1:0] wa0;
    logic [7:0] byte1;
  } plan_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       poll;
    logic [6:0] wb;
    logic [1:0] wa;
    logic       last;
  } beat_t;

  function automatic logic [7:0] ddram_cmd(input logic [5:0] col, input logic [1:0] row,
                                           input logic [2:0] rows, input logic [5:0] cols);
    logic [7:0] addr;
    addr = {2'b00, col};
    if (rows == ROWS_TWO) begin
      if (row != 2'd0) addr = addr + DDRAM_ROW_ODD;
    end else if (rows == ROWS_FOUR) begin
      case (row)
        2'd1:    addr = addr + DDRAM_ROW_ODD;
        2'd2:    addr = addr + {2'b00, cols};
        2'd3:    addr = addr + DDRAM_ROW_ODD + {2'b00, cols};
        default: addr = addr;
      endcase
    end
    return CMD_SET_DDRAM | addr;
  endfunction

  // One round of the power-up sequence; the last beat flag is filled in later.
  function automatic beat_t init_beat(input logic [3:0] i);
    beat_t b;
    b = '0;
    case (i)
      4'd0:    begin b.nib = NIB_8BIT_MODE; b.wb = WAIT_POWER_UP; end
      4'd1:    begin b.nib = NIB_8BIT_MODE; b.wb = WAIT_SECOND; end
      4'd2:    begin b.nib = NIB_8BIT_MODE; b.wb = WAIT_SHORT; end
      4'd3:    begin b.nib = NIB_4BIT_MODE; b.wb = WAIT_SHORT; end
      4'd4:    begin b.nib = CMD_FUNCTION_SET[7:4]; b.wb = WAIT_SHORT; end
      4'd5:    b.nib = CMD_FUNCTION_SET[3:0];
      4'd6:    begin b.nib = CMD_DISPLAY_OFF[7:4]; b.poll = 1'b1; end
      4'd7:    b.nib = CMD_DISPLAY_OFF[3:0];
      4'd8:    begin b.nib = CMD_CLEAR[7:4]; b.poll = 1'b1; end
      4'd9:    begin b.nib = CMD_CLEAR[3:0]; b.wa = WAIT_CLEAR; end
      4'd10:   begin b.nib = CMD_ENTRY_MODE[7:4]; b.poll = 1'b1; end
      4'd11:   b.nib = CMD_ENTRY_MODE[3:0];
      4'd12:   begin b.nib = CMD_BLINK_ON[7:4]; b.poll = 1'b1; end
      4'd13:   b.nib = CMD_BLINK_ON[3:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

/* design/clcs_planner.sv */
module clcs_planner (
  input  logic [2:0]       mode,
  input  logic [7:0]       char_code,
  input  logic [5:0]       column,
  input  logic [1:0]       row,
  input  logic [2:0]       row_count,
  input  logic [5:0]       column_count,
  input  clcs_pkg::cursor_t cursor,
  output clcs_pkg::plan_t   plan,
  output clcs_pkg::cursor_t cursor_next
);
  import clcs_pkg::*;

  logic [6:0] col_inc;
  logic [6:0] wrap_limit;
  logic [1:0] wrap_row;

  always_comb begin
    col_inc    = {1'b0, cursor.column} + 7'd1;
    wrap_limit = (row_count == ROWS_FOUR) ? WRAP_FOUR_ROWS : WRAP_OTHER;
    if (row_count == ROWS_FOUR) begin
      wrap_row = cursor.row + 2'd1;
    end else if (row_count == ROWS_TWO) begin
      wrap_row = (cursor.row == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      wrap_row = cursor.row;
    end

    plan.kind   = KIND_BYTES;
    plan.count  = 5'd0;
    plan.rs0    = 1'b0;
    plan.byte0  = 8'h00;
    plan.wa0    = 2'd0;
    plan.byte1  = 8'h00;
    cursor_next = cursor;

    case (mode)
      MODE_INIT: begin
        plan.kind   = KIND_INIT;
        plan.count  = BEATS_INIT;
        cursor_next = '0;
      end
      MODE_CLEAR: begin
        plan.count = BEATS_BYTE;
        plan.byte0 = CMD_CLEAR;
        plan.wa0   = WAIT_CLEAR;
      end
      MODE_CURSOR_ON: begin
        plan.count = BEATS_BYTE;
        plan.byte0 = CMD_CURSOR_ON;
      end
      MODE_CURSOR_OFF: begin
        plan.count = BEATS_BYTE;
        plan.byte0 = CMD_CURSOR_OFF;
      end
      MODE_GOTO: begin
        plan.count         = BEATS_BYTE;
        plan.byte0         = ddram_cmd(column, row, row_count, column_count);
        cursor_next.row    = row;
        cursor_next.column = column;
      end
      MODE_PUTCHAR: begin
        plan.rs0   = 1'b1;
        plan.byte0 = char_code;
        plan.byte1 = ddram_cmd(6'd0, wrap_row, row_count, column_count);
        // Reaching the line end goes to column 0 of the next row with a goto (same row if rows is not 2 or 4).
        if (col_inc >= wrap_limit) begin
          plan.count         = BEATS_WRAP;
          cursor_next.row    = wrap_row;
          cursor_next.column = 6'd0;
        end else begin
          plan.count         = BEATS_BYTE;
          cursor_next.column = col_inc[5:0];
        end
      end
      default: plan.count = 5'd0;
    endcase
  end

endmodule

/* design/clcs_nibble_gen.sv */
module clcs_nibble_gen (
  input  clcs_pkg::plan_t plan,
  input  logic [4:0]      idx,
  output clcs_pkg::beat_t beat
);
  import clcs_pkg::*;

  logic [4:0] round_idx;
  logic [7:0] cur_byte;

  always_comb begin
    round_idx = (idx >= BEATS_ROUND) ? idx - BEATS_ROUND : idx;
    cur_byte  = idx[1] ? plan.byte1 : plan.byte0;
    if (plan.kind == KIND_INIT) begin
      beat = init_beat(round_idx[3:0]);
    end else begin
      // Beats 0 and 1 carry the command byte, beats 2 and 3 the wrap goto.
      beat.rs   = idx[1] ? 1'b0 : plan.rs0;
      beat.nib  = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
      beat.poll = ~idx[0];
      beat.wb   = 7'd0;
      beat.wa   = (idx[0] && !idx[1]) ? plan.wa0 : 2'd0;
      beat.last = 1'b0;
    end
    beat.last = (idx == plan.count - 5'd1);
  end

endmodule

/* design/char_lcd_command_sequencer_unit.sv */
// Character LCD command sequencer for a controller on a 4-bit bus.
// Commands (init, clear, cursor on/off, goto, put character) arrive as beats on the
// in_valid/in_ready channel. Each command expands into nibble beats on the
// out_valid/out_ready channel, high nibble first, with register select, busy-poll flag,
// the waits before and after the write, and last set on the final beat.
// Beat counts: init 28, put character 2 or 4 (4 when the cursor wraps), others 2.
// Modes 6 and 7 are taken and produce nothing.
// A taken command is registered as the held command with its beat counter cleared; its
// first beat then passes through the output register before out_valid rises.
// Throughput: one nibble per cycle from a beat counter over the held command.
// The next command is taken in the cycle the previous command's last beat enters
// the output register. If the receiver stalls, the output register holds its beat
// and the counter waits.
// The user writes configuration (cfg_write, cfg_index, cfg_data) while the unit is idle;
// the unit does not enforce this. Index 0 is row_count, index 1 is column_count.
// Reset (synchronous, rst) empties the pipeline, puts the cursor at row 0 column 0
// and restores two rows of sixteen columns.
module char_lcd_command_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [7:0] char_code,
  input  logic [5:0] column,
  input  logic [1:0] row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       register_select,
  output logic [3:0] nibble,
  output logic       poll_busy,
  output logic [6:0] wait_before_ms,
  output logic [1:0] wait_after_ms,
  output logic       last
);
  import clcs_pkg::*;

  logic [2:0] row_count;
  logic [5:0] column_count;
  cursor_t    cursor;
  cursor_t    cursor_next;
  plan_t      plan_next;
  plan_t      cmd;
  logic       busy;
  logic [4:0] idx;
  beat_t      beat;
  logic       emit;
  logic       accept;

  clcs_planner u_planner (
    .mode         (mode),
    .char_code    (char_code),
    .column       (column),
    .row          (row),
    .row_count    (row_count),
    .column_count (column_count),
    .cursor       (cursor),
    .plan         (plan_next),
    .cursor_next  (cursor_next)
  );

  clcs_nibble_gen u_nibble_gen (
    .plan (cmd),
    .idx  (idx),
    .beat (beat)
  );

  assign emit     = busy && (!out_valid || out_ready);
  assign in_ready = !rst && (!busy || (emit && beat.last));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
      cursor       <= '0;
      busy         <= 1'b0;
      idx          <= 5'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_COUNT:    row_count <= cfg_data[2:0];
          CFG_COLUMN_COUNT: column_count <= cfg_data;
          default:          row_count <= row_count;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        // The cursor moves when the command is taken, so the next one plans from it.
        cmd    <= plan_next;
        cursor <= cursor_next;
        busy   <= (plan_next.count != 5'd0);
        idx    <= 5'd0;
      end else begin
        if (emit) begin
          idx <= idx + 5'd1;
        end
        if (emit && beat.last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      register_select <= beat.rs;
      nibble          <= beat.nib;
      poll_busy       <= beat.poll;
      wait_before_ms  <= beat.wb;
      wait_after_ms   <= beat.wa;
      last            <= beat.last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cmd.count))
    else $error("beat counter ran past the command length");

  a_poll_not_with_wait_after: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(poll_busy && (wait_after_ms != 2'd0)))
    else $error("a polled high nibble carries a wait after it");

  a_unused_mode_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode > MODE_PUTCHAR)) |=> !busy)
    else $error("an unused mode started a sequence");

  a_init_length: assert property (@(posedge clk) disable iff (rst)
    (busy && cmd.kind == KIND_INIT) |-> (cmd.count == BEATS_INIT))
    else $error("init sequence has the wrong length");

endmodule

/* tb/sv/lcd_nibble_ledger_pkg.sv */
package lcd_nibble_ledger_pkg;
  import clcs_pkg::*;

  // Tracks the display geometry and cursor, expands each accepted command into
  // the nibble beats the unit must produce, and checks them in order.
  class nibble_ledger;
    beat_t      expected_nibbles[$];
    beat_t      cmd_nibbles[$];
    logic [2:0] rows;
    logic [5:0] cols;
    logic [1:0] cur_row;
    logic [5:0] cur_col;
    int         mismatches;
    int         checked;
    int         wraps;

    function new();
      rows       = ROW_COUNT_RESET;
      cols       = COLUMN_COUNT_RESET;
      cur_row    = 2'd0;
      cur_col    = 6'd0;
      mismatches = 0;
      checked    = 0;
      wraps      = 0;
    endfunction

    function void set_geometry(logic [2:0] r, logic [5:0] c);
      rows = r;
      cols = c;
    endfunction

    function int pending();
      return expected_nibbles.size();
    endfunction

    function void push_nibble(logic rs, logic [3:0] nib, logic poll, logic [6:0] wb,
                              logic [1:0] wa);
      beat_t b;
      b      = '0;
      b.rs   = rs;
      b.nib  = nib;
      b.poll = poll;
      b.wb   = wb;
      b.wa   = wa;
      cmd_nibbles.push_back(b);
    endfunction

    // The wait before goes with the high nibble, the wait after with the low one.
    function void push_byte(logic rs, logic [7:0] v, logic poll, logic [6:0] wb,
                            logic [1:0] wa);
      push_nibble(rs, v[7:4], poll, wb, 2'd0);
      push_nibble(rs, v[3:0], 1'b0, 7'd0, wa);
    endfunction

    function void move_cursor(logic [5:0] col, logic [1:0] row);
      logic [7:0] addr;
      addr = {2'b00, col};
      if (rows == ROWS_TWO) begin
        if (row != 2'd0) addr = addr + DDRAM_ROW_ODD;
      end else if (rows == ROWS_FOUR) begin
        if (row == 2'd1) addr = addr + DDRAM_ROW_ODD;
        else if (row == 2'd2) addr = addr + {2'b00, cols};
        else if (row == 2'd3) addr = addr + DDRAM_ROW_ODD + {2'b00, cols};
      end
      push_byte(1'b0, CMD_SET_DDRAM | addr, 1'b1, 7'd0, 2'd0);
      cur_row = row;
      cur_col = col;
    endfunction

    function void power_up();
      repeat (2) begin
        push_nibble(1'b0, NIB_8BIT_MODE, 1'b0, WAIT_POWER_UP, 2'd0);
        push_nibble(1'b0, NIB_8BIT_MODE, 1'b0, WAIT_SECOND, 2'd0);
        push_nibble(1'b0, NIB_8BIT_MODE, 1'b0, WAIT_SHORT, 2'd0);
        push_nibble(1'b0, NIB_4BIT_MODE, 1'b0, WAIT_SHORT, 2'd0);
        push_byte(1'b0, CMD_FUNCTION_SET, 1'b0, WAIT_SHORT, 2'd0);
        push_byte(1'b0, CMD_DISPLAY_OFF, 1'b1, 7'd0, 2'd0);
        push_byte(1'b0, CMD_CLEAR, 1'b1, 7'd0, WAIT_CLEAR);
        push_byte(1'b0, CMD_ENTRY_MODE, 1'b1, 7'd0, 2'd0);
        push_byte(1'b0, CMD_BLINK_ON, 1'b1, 7'd0, 2'd0);
      end
      cur_row = 2'd0;
      cur_col = 6'd0;
    endfunction

    // A cursor parked past the limit by a goto also wraps on the next character.
    function void put_char(logic [7:0] ch);
      logic [6:0] next_col;
      logic [6:0] limit;
      push_byte(1'b1, ch, 1'b1, 7'd0, 2'd0);
      next_col = {1'b0, cur_col} + 7'd1;
      limit    = (rows == ROWS_FOUR) ? WRAP_FOUR_ROWS : WRAP_OTHER;
      if (next_col >= limit) begin
        wraps++;
        if (rows == ROWS_FOUR) move_cursor(6'd0, cur_row + 2'd1);
        else if (rows == ROWS_TWO) move_cursor(6'd0, (cur_row == 2'd0) ? 2'd1 : 2'd0);
        else move_cursor(6'd0, cur_row);
      end else begin
        cur_col = next_col[5:0];
      end
    endfunction

    function void note_command(logic [2:0] m, logic [7:0] ch, logic [5:0] col,
                               logic [1:0] row);
      beat_t b;
      cmd_nibbles.delete();
      case (m)
        MODE_INIT:       power_up();
        MODE_CLEAR:      push_byte(1'b0, CMD_CLEAR, 1'b1, 7'd0, WAIT_CLEAR);
        MODE_CURSOR_ON:  push_byte(1'b0, CMD_CURSOR_ON, 1'b1, 7'd0, 2'd0);
        MODE_CURSOR_OFF: push_byte(1'b0, CMD_CURSOR_OFF, 1'b1, 7'd0, 2'd0);
        MODE_GOTO:       move_cursor(col, row);
        MODE_PUTCHAR:    put_char(ch);
        default:         ;
      endcase
      if (cmd_nibbles.size() > 0) begin
        b = cmd_nibbles.pop_back();
        b.last = 1'b1;
        cmd_nibbles.push_back(b);
      end
      foreach (cmd_nibbles[i]) expected_nibbles.push_back(cmd_nibbles[i]);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("nibble %0d %s got %0d expected %0d", checked, name, got, want));
    endtask

    task check_nibble(beat_t got);
      beat_t want;
      if (expected_nibbles.size() == 0) begin
        report($sformatf("nibble %0h (rs %0d) arrived with nothing outstanding",
                         got.nib, got.rs));
        return;
      end
      want = expected_nibbles.pop_front();
      checked++;
      compare_field("register_select", got.rs, want.rs);
      compare_field("nibble", got.nib, want.nib);
      compare_field("poll_busy", got.poll, want.poll);
      compare_field("wait_before_ms", got.wb, want.wb);
      compare_field("wait_after_ms", got.wa, want.wa);
      compare_field("last", got.last, want.last);
    endtask

    task flush_leftovers();
      if (expected_nibbles.size() != 0)
        report($sformatf("%0d nibbles never arrived", expected_nibbles.size()));
    endtask
  endclass

endpackage

/* tb/sv/tb_char_lcd_command_sequencer_unit.sv */
module tb_char_lcd_command_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import clcs_pkg::*;
  import lcd_nibble_ledger_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 15;
  localparam int SETTLE_CYCLES = 8;

  // Geometries for the random phases; the row register keeps only the low three bits.
  localparam logic [5:0] ROWS_PLAN [PHASES] = '{6'd4, 6'd1, 6'd4, 6'h3F,
                                                6'h08, 6'd3, 6'd4, 6'd2};
  localparam logic [5:0] COLS_PLAN [PHASES] = '{6'd20, 6'd40, 6'd8, 6'd63,
                                                6'd17, 6'd40, 6'd40, 6'd16};

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = CFG_ROW_COUNT;
  logic [5:0] cfg_data  = 6'd0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [2:0] mode      = MODE_INIT;
  logic [7:0] char_code = 8'd0;
  logic [5:0] column    = 6'd0;
  logic [1:0] row       = 2'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       register_select;
  logic [3:0] nibble;
  logic       poll_busy;
  logic [6:0] wait_before_ms;
  logic [1:0] wait_after_ms;
  logic       last;

  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  int commands_sent   = 0;
  int geometries      = 0;

  nibble_ledger ledger = new();

  char_lcd_command_sequencer_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_nibble(beat_t'({register_select, nibble, poll_busy, wait_before_ms,
                                   wait_after_ms, last}));
  end

  // Receiver: a fresh stall before every beat, with occasional stall-free stretches.
  initial begin : receiver
    int stall;
    int beats;
    beats = 0;
    @(posedge clk);
    forever begin
      if (beats % 16 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      stall = receiver_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      beats++;
    end
  end

  // Valid is left high after a beat; the next call either replaces the payload in
  // the same step or drops valid, so no command is ever taken twice.
  task automatic send_command(input logic [2:0] m, input logic [7:0] ch,
                              input logic [5:0] col, input logic [1:0] r);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    char_code <= ch;
    column    <= col;
    row       <= r;
    do @(posedge clk); while (!in_ready);
    ledger.note_command(m, ch, col, r);
    commands_sent++;
  endtask

  // Modes 6 and 7 produce nothing and add nothing to the queue. Valid is dropped, and
  // the task waits for the queue to empty and then for the settle period.
  task automatic drain_outputs();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (ledger.pending() != 0 && waited < 20000);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [5:0] rows_data, input logic [5:0] cols_data);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rows_data;
    @(posedge clk);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= cols_data;
    @(posedge clk);
    cfg_write <= 1'b0;
    ledger.set_geometry(rows_data[2:0], cols_data);
    geometries++;
  endtask

  // Mostly characters and gotos, half of the gotos close to the wrap point, so the cursor wraps often.
  task automatic random_command();
    int         pick;
    int         limit;
    logic [5:0] col;
    pick  = $urandom_range(0, 99);
    limit = (ledger.rows == ROWS_FOUR) ? 20 : 40;
    col   = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'(limit - $urandom_range(1, 3));
    if (pick < 55)
      send_command(MODE_PUTCHAR, 8'($urandom), 6'($urandom), 2'($urandom));
    else if (pick < 75)
      send_command(MODE_GOTO, 8'($urandom), col, 2'($urandom));
    else if (pick < 81)
      send_command(MODE_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
    else if (pick < 86)
      send_command(MODE_CURSOR_ON, 8'($urandom), 6'($urandom), 2'($urandom));
    else if (pick < 91)
      send_command(MODE_CURSOR_OFF, 8'($urandom), 6'($urandom), 2'($urandom));
    else if (pick < 94)
      send_command(MODE_INIT, 8'($urandom), 6'($urandom), 2'($urandom));
    else
      send_command($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO,
                   8'($urandom), 6'($urandom), 2'($urandom));
  endtask

  initial begin : stimulus
    int pause_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed commands on the reset geometry of two rows by sixteen.
    send_command(MODE_INIT, 8'h00, 6'd0, 2'd0);
    send_command(MODE_CLEAR, 8'hFF, 6'd63, 2'd3);
    send_command(MODE_CURSOR_ON, 8'h00, 6'd0, 2'd0);
    send_command(MODE_CURSOR_OFF, 8'h00, 6'd0, 2'd0);
    send_command(MODE_GOTO, 8'h00, 6'd0, 2'd0);
    send_command(MODE_GOTO, 8'hFF, 6'd39, 2'd3);
    send_command(MODE_PUTCHAR, 8'hFF, 6'd63, 2'd3);
    send_command(MODE_GOTO, 8'h00, 6'd63, 2'd2);
    send_command(MODE_PUTCHAR, 8'h00, 6'd0, 2'd0);
    send_command(MODE_SPARE_LO, 8'hFF, 6'd63, 2'd3);
    send_command(MODE_SPARE_HI, 8'h00, 6'd0, 2'd0);
    send_command(MODE_GOTO, 8'h00, 6'd38, 2'd1);
    send_command(MODE_PUTCHAR, 8'hA5, 6'd0, 2'd0);
    send_command(MODE_PUTCHAR, 8'h5A, 6'd0, 2'd0);
    send_command(MODE_PUTCHAR, 8'h41, 6'd0, 2'd0);
    drain_outputs();

    for (int p = 0; p < PHASES; p++) begin
      write_geometry(ROWS_PLAN[p], COLS_PLAN[p]);
      pause_at = $urandom_range(3, PHASE_ITEMS - 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 5 == 0) sender_steady = ($urandom_range(0, 3) == 0);
        if (i == pause_at) drain_outputs();
        random_command();
      end
      drain_outputs();
    end

    ledger.flush_leftovers();
    $display("Sent %0d commands over %0d display geometries besides the reset one.",
             commands_sent, geometries);
    $display("Checked %0d nibbles, %0d of the commands wrapped the cursor.",
             ledger.checked, ledger.wraps);
    if (ledger.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Run stopped by the time limit.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
